[rtl/tskf_pkg.sv]
// shared types, constants and the microprogram of the two-state kalman filter
package tskf_pkg;

    // default fixed-point format
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // field and configuration widths
    localparam int FIELD_W   = 32;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBS_POS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBS_VEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PNOISE_P = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PNOISE_V = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MNOISE   = 3'd5;

    // configuration reset values
    localparam logic [30:0] RST_STEP_DT  = 31'd6554;
    localparam logic [31:0] RST_OBS_POS  = 32'd65536;
    localparam logic [31:0] RST_OBS_VEL  = 32'd0;
    localparam logic [30:0] RST_PNOISE_P = 31'd1;
    localparam logic [30:0] RST_PNOISE_V = 31'd1;
    localparam logic [30:0] RST_MNOISE   = 31'd1;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SKIP = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // micro operations
    typedef enum logic [2:0] {
        OP_LDX,
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_MOV,
        OP_DIV,
        OP_CHK,
        OP_END
    } t_op;

    typedef logic [4:0] t_addr;

    // register file slots
    localparam t_addr R_POS = 5'd0;
    localparam t_addr R_VEL = 5'd1;
    localparam t_addr R_C00 = 5'd2;
    localparam t_addr R_C01 = 5'd3;
    localparam t_addr R_C10 = 5'd4;
    localparam t_addr R_C11 = 5'd5;
    localparam t_addr R_DT  = 5'd6;
    localparam t_addr R_H0  = 5'd7;
    localparam t_addr R_H1  = 5'd8;
    localparam t_addr R_Q0  = 5'd9;
    localparam t_addr R_Q1  = 5'd10;
    localparam t_addr R_RN  = 5'd11;
    localparam t_addr R_Z   = 5'd12;
    localparam t_addr R_XP0 = 5'd13;
    localparam t_addr R_R00 = 5'd14;
    localparam t_addr R_R01 = 5'd15;
    localparam t_addr R_P00 = 5'd16;
    localparam t_addr R_P10 = 5'd17;
    localparam t_addr R_P11 = 5'd18;
    localparam t_addr R_T0  = 5'd19;
    localparam t_addr R_T1  = 5'd20;
    localparam t_addr R_S   = 5'd21;
    localparam t_addr R_KP  = 5'd22;
    localparam t_addr R_KV  = 5'd23;
    localparam t_addr R_INN = 5'd24;
    localparam t_addr R_U0  = 5'd25;
    localparam t_addr R_U1  = 5'd26;
    localparam t_addr R_M   = 5'd27;
    localparam t_addr R_M2  = 5'd28;

    // external operand selects for a load
    localparam t_addr X_DT  = 5'd0;
    localparam t_addr X_H0  = 5'd1;
    localparam t_addr X_H1  = 5'd2;
    localparam t_addr X_Q0  = 5'd3;
    localparam t_addr X_Q1  = 5'd4;
    localparam t_addr X_RN  = 5'd5;
    localparam t_addr X_Z   = 5'd6;
    localparam t_addr X_LP  = 5'd7;
    localparam t_addr X_LV  = 5'd8;
    localparam t_addr X_L00 = 5'd9;
    localparam t_addr X_L01 = 5'd10;
    localparam t_addr X_L10 = 5'd11;
    localparam t_addr X_L11 = 5'd12;

    typedef struct packed {
        t_op   op;
        t_addr dst;
        t_addr a;
        t_addr b;
    } t_instr;

    // program counter and entry points
    localparam int PC_W = 7;
    localparam logic [PC_W-1:0] PC_MEAS = 7'd0;
    localparam logic [PC_W-1:0] PC_SKIP = 7'd55;
    localparam logic [PC_W-1:0] PC_LOAD = 7'd62;

    function automatic t_instr ins(input t_op op, input t_addr d, input t_addr a,
                                   input t_addr b);
        t_instr r;
        r.op  = op;
        r.dst = d;
        r.a   = a;
        r.b   = b;
        return r;
    endfunction

    // microprogram: measure update, skip path, load
    function automatic t_instr prog(input logic [PC_W-1:0] pc);
        t_instr r;
        unique case (pc)
            // operands from configuration and the item
            7'd0:  r = ins(OP_LDX, R_DT,  X_DT,  R_POS);
            7'd1:  r = ins(OP_LDX, R_H0,  X_H0,  R_POS);
            7'd2:  r = ins(OP_LDX, R_H1,  X_H1,  R_POS);
            7'd3:  r = ins(OP_LDX, R_Q0,  X_Q0,  R_POS);
            7'd4:  r = ins(OP_LDX, R_Q1,  X_Q1,  R_POS);
            7'd5:  r = ins(OP_LDX, R_RN,  X_RN,  R_POS);
            7'd6:  r = ins(OP_LDX, R_Z,   X_Z,   R_POS);
            // state and covariance prediction
            7'd7:  r = ins(OP_MUL, R_M,   R_DT,  R_VEL);
            7'd8:  r = ins(OP_ADD, R_XP0, R_POS, R_M);
            7'd9:  r = ins(OP_MUL, R_M,   R_DT,  R_C10);
            7'd10: r = ins(OP_ADD, R_R00, R_C00, R_M);
            7'd11: r = ins(OP_MUL, R_M,   R_DT,  R_C11);
            7'd12: r = ins(OP_ADD, R_R01, R_C01, R_M);
            7'd13: r = ins(OP_MUL, R_M,   R_R01, R_DT);
            7'd14: r = ins(OP_ADD, R_M,   R_R00, R_M);
            7'd15: r = ins(OP_ADD, R_P00, R_M,   R_Q0);
            7'd16: r = ins(OP_MUL, R_M,   R_C11, R_DT);
            7'd17: r = ins(OP_ADD, R_P10, R_C10, R_M);
            7'd18: r = ins(OP_ADD, R_P11, R_C11, R_Q1);
            // innovation covariance
            7'd19: r = ins(OP_MUL, R_M,   R_P00, R_H0);
            7'd20: r = ins(OP_MUL, R_M2,  R_R01, R_H1);
            7'd21: r = ins(OP_ADD, R_T0,  R_M,   R_M2);
            7'd22: r = ins(OP_MUL, R_M,   R_P10, R_H0);
            7'd23: r = ins(OP_MUL, R_M2,  R_P11, R_H1);
            7'd24: r = ins(OP_ADD, R_T1,  R_M,   R_M2);
            7'd25: r = ins(OP_MUL, R_M,   R_H0,  R_T0);
            7'd26: r = ins(OP_MUL, R_M2,  R_H1,  R_T1);
            7'd27: r = ins(OP_ADD, R_M,   R_M,   R_M2);
            7'd28: r = ins(OP_ADD, R_S,   R_RN,  R_M);
            7'd29: r = ins(OP_CHK, R_S,   R_S,   R_S);
            // gain
            7'd30: r = ins(OP_DIV, R_KP,  R_T0,  R_S);
            7'd31: r = ins(OP_DIV, R_KV,  R_T1,  R_S);
            // state update
            7'd32: r = ins(OP_MUL, R_M,   R_H0,  R_XP0);
            7'd33: r = ins(OP_MUL, R_M2,  R_H1,  R_VEL);
            7'd34: r = ins(OP_ADD, R_M,   R_M,   R_M2);
            7'd35: r = ins(OP_SUB, R_INN, R_Z,   R_M);
            7'd36: r = ins(OP_MUL, R_M,   R_KP,  R_INN);
            7'd37: r = ins(OP_ADD, R_POS, R_XP0, R_M);
            7'd38: r = ins(OP_MUL, R_M,   R_KV,  R_INN);
            7'd39: r = ins(OP_ADD, R_VEL, R_VEL, R_M);
            // covariance update
            7'd40: r = ins(OP_MUL, R_M,   R_H0,  R_P00);
            7'd41: r = ins(OP_MUL, R_M2,  R_H1,  R_P10);
            7'd42: r = ins(OP_ADD, R_U0,  R_M,   R_M2);
            7'd43: r = ins(OP_MUL, R_M,   R_H0,  R_R01);
            7'd44: r = ins(OP_MUL, R_M2,  R_H1,  R_P11);
            7'd45: r = ins(OP_ADD, R_U1,  R_M,   R_M2);
            7'd46: r = ins(OP_MUL, R_M,   R_KP,  R_U0);
            7'd47: r = ins(OP_SUB, R_C00, R_P00, R_M);
            7'd48: r = ins(OP_MUL, R_M,   R_KP,  R_U1);
            7'd49: r = ins(OP_SUB, R_C01, R_R01, R_M);
            7'd50: r = ins(OP_MUL, R_M,   R_KV,  R_U0);
            7'd51: r = ins(OP_SUB, R_C10, R_P10, R_M);
            7'd52: r = ins(OP_MUL, R_M,   R_KV,  R_U1);
            7'd53: r = ins(OP_SUB, R_C11, R_P11, R_M);
            7'd54: r = ins(OP_END, R_POS, R_POS, R_POS);
            // denominator not positive: keep the prediction
            7'd55: r = ins(OP_MOV, R_POS, R_XP0, R_XP0);
            7'd56: r = ins(OP_MOV, R_VEL, R_VEL, R_VEL);
            7'd57: r = ins(OP_MOV, R_C00, R_P00, R_P00);
            7'd58: r = ins(OP_MOV, R_C01, R_R01, R_R01);
            7'd59: r = ins(OP_MOV, R_C10, R_P10, R_P10);
            7'd60: r = ins(OP_MOV, R_C11, R_P11, R_P11);
            7'd61: r = ins(OP_END, R_POS, R_POS, R_POS);
            // load of state and covariance
            7'd62: r = ins(OP_LDX, R_POS, X_LP,  R_POS);
            7'd63: r = ins(OP_LDX, R_VEL, X_LV,  R_POS);
            7'd64: r = ins(OP_LDX, R_C00, X_L00, R_POS);
            7'd65: r = ins(OP_LDX, R_C01, X_L01, R_POS);
            7'd66: r = ins(OP_LDX, R_C10, X_L10, R_POS);
            7'd67: r = ins(OP_LDX, R_C11, X_L11, R_POS);
            default: r = ins(OP_END, R_POS, R_POS, R_POS);
        endcase
        return r;
    endfunction

endpackage

[rtl/tskf_div.sv]
// iterative restoring divider for the fixed-point gain, one quotient bit per cycle
module tskf_div #(
    parameter int DATA_WIDTH = tskf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = tskf_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DATA_WIDTH-1:0] i_num,
    input  logic signed [DATA_WIDTH-1:0] i_den,
    output logic                         o_done,
    output logic signed [DATA_WIDTH-1:0] o_q,
    output logic                         o_ovf
);
    localparam int W  = DATA_WIDTH;
    localparam int N  = DATA_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(N + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [N-1:0]  r_dvd;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_den;
    logic          r_neg;

    logic [W-1:0]  w_mag;
    logic [W:0]    w_rem_sh;
    logic [W:0]    w_diff;
    logic          w_ge;
    logic [N-1:0]  w_lim;
    logic [N-1:0]  w_qm;
    logic [W-1:0]  w_ql;

    // one shift-subtract step
    always_comb begin
        w_mag    = i_num[W-1] ? (~i_num + 1'b1) : i_num;
        w_rem_sh = {r_rem, r_dvd[N-1]};
        w_diff   = w_rem_sh - {1'b0, r_den};
        w_ge     = w_rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(N);
            r_neg  <= i_num[W-1];
            r_dvd  <= {w_mag, {FRAC_BITS{1'b0}}};
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[W-1:0] : w_rem_sh[W-1:0];
            r_dvd  <= {r_dvd[N-2:0], w_ge};
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // saturate the magnitude and restore the sign
    always_comb begin
        w_lim = {{(FRAC_BITS + 1){1'b0}}, {(W - 1){1'b1}}} + N'(r_neg);
        o_ovf = r_dvd > w_lim;
        w_qm  = o_ovf ? w_lim : r_dvd;
        w_ql  = w_qm[W-1:0];
        o_q   = r_neg ? (~w_ql + 1'b1) : w_ql;
    end

    assign o_done = r_done;

endmodule

[rtl/tskf_alu.sv]
// shared arithmetic unit: saturating fixed-point multiply, add, subtract and load
module tskf_alu #(
    parameter int DATA_WIDTH = tskf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = tskf_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  tskf_pkg::t_op                i_op,
    input  logic signed [DATA_WIDTH-1:0] i_a,
    input  logic signed [DATA_WIDTH-1:0] i_b,
    input  logic signed [32:0]           i_ext,
    output logic signed [DATA_WIDTH-1:0] o_res,
    output logic                         o_sat
);
    localparam int W  = DATA_WIDTH;
    localparam int XW = ((W > 33) ? W : 33) + 1;

    logic [W-1:0]          w_ua;
    logic [W-1:0]          w_ub;
    logic [2*W-1:0]        w_prod;
    logic [2*W-1:0]        w_mag;
    logic [2*W-1:0]        w_lim;
    logic [2*W-1:0]        w_mmag;
    logic [W-1:0]          w_mlow;
    logic                  w_neg;
    logic                  w_msat;
    logic signed [W:0]     w_sum;
    logic signed [XW-1:0]  w_xv;
    logic signed [XW-1:0]  w_xmax;
    logic signed [XW-1:0]  w_xmin;
    logic signed [W-1:0]   w_max;
    logic signed [W-1:0]   w_min;
    logic signed [W-1:0]   n_res;
    logic                  n_sat;
    logic signed [W-1:0]   r_res;
    logic                  r_sat;

    // sign-magnitude product, truncated toward zero and clamped
    always_comb begin
        w_neg  = i_a[W-1] ^ i_b[W-1];
        w_ua   = i_a[W-1] ? (~i_a + 1'b1) : i_a;
        w_ub   = i_b[W-1] ? (~i_b + 1'b1) : i_b;
        w_prod = {{W{1'b0}}, w_ua} * {{W{1'b0}}, w_ub};
        w_mag  = w_prod >> FRAC_BITS;
        w_lim  = {{(W + 1){1'b0}}, {(W - 1){1'b1}}} + (2*W)'(w_neg);
        w_msat = w_mag > w_lim;
        w_mmag = w_msat ? w_lim : w_mag;
        w_mlow = w_mmag[W-1:0];
    end

    // operation select with saturation
    always_comb begin
        w_max  = {1'b0, {(W - 1){1'b1}}};
        w_min  = ~w_max;
        w_xv   = XW'(i_ext);
        w_xmax = {{(XW - W + 1){1'b0}}, {(W - 1){1'b1}}};
        w_xmin = ~w_xmax;
        w_sum  = '0;
        n_res  = i_a;
        n_sat  = 1'b0;
        case (i_op) inside
            tskf_pkg::OP_MUL: begin
                n_res = w_neg ? (~w_mlow + 1'b1) : w_mlow;
                n_sat = w_msat;
            end
            tskf_pkg::OP_ADD, tskf_pkg::OP_SUB: begin
                if (i_op == tskf_pkg::OP_ADD) begin
                    w_sum = {i_a[W-1], i_a} + {i_b[W-1], i_b};
                end else begin
                    w_sum = {i_a[W-1], i_a} - {i_b[W-1], i_b};
                end
                n_sat = w_sum[W] != w_sum[W-1];
                n_res = n_sat ? (w_sum[W] ? w_min : w_max) : w_sum[W-1:0];
            end
            tskf_pkg::OP_LDX: begin
                if (w_xv > w_xmax) begin
                    n_res = w_max;
                    n_sat = 1'b1;
                end else if (w_xv < w_xmin) begin
                    n_res = w_min;
                    n_sat = 1'b1;
                end else begin
                    n_res = w_xv[W-1:0];
                end
            end
            default: begin
                n_res = i_a;
                n_sat = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_sat <= n_sat;
    end

    assign o_res = r_res;
    assign o_sat = r_sat;

endmodule

[rtl/two_state_kalman_filter_unit.sv]
// top level of the two-state kalman filter: sequencer, register file and shared units
//
// Two-state (position, velocity) Kalman filter with one scalar measurement per item, in
// fixed point (Q16.16 by default). A transfer with tuser 0 runs a measurement update:
// predict x and P, form S = R + H*P*H', gain K = P*H'/S, then update x and P. A transfer
// with tuser 1 loads state and covariance. Every item gives one result; status 1 means
// S was not positive and the prediction was kept, status 2 means some value saturated.
// The block takes one item at a time: a small microprogram drives one saturating
// multiply/add unit, each micro op passing through register read, execute and
// write-back, the sign check through register read and execute and the end through a
// single fetch, and the two gain divisions use a restoring divider.
// Configuration writes are taken at any time but should only be issued while idle.
module two_state_kalman_filter_unit #(
    parameter int DATA_WIDTH = tskf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = tskf_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [tskf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_wdata,
    // input items
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // measurement, load_pos, load_vel, load_p00, load_p01, load_p10, load_p11
    input  logic [223:0]                   s_axis_tdata,
    // cmd
    input  logic [0:0]                     s_axis_tuser,
    // result items
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // est_pos, est_vel, gain_pos, gain_vel
    output logic [127:0]                   m_axis_tdata,
    // status
    output logic [1:0]                     m_axis_tuser
);
    localparam int W = DATA_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_DIVW,
        S_WB,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration registers
    logic [30:0] r_dt;
    logic [31:0] r_h0;
    logic [31:0] r_h1;
    logic [30:0] r_q0;
    logic [30:0] r_q1;
    logic [30:0] r_rn;

    // sequencer
    logic [tskf_pkg::PC_W-1:0] r_pc;
    logic [223:0]              r_in;
    logic                      r_sat;
    logic                      r_skip;
    logic [31:0]               r_valid;
    logic                      r_vld_a;
    logic                      r_vld_b;
    logic                      r_out_valid;
    logic [1:0]                r_status;
    logic [31:0]               r_out_pos;
    logic [31:0]               r_out_vel;
    logic [31:0]               r_out_kp;
    logic [31:0]               r_out_kv;

    // register file
    logic [W-1:0] r_mem [32];
    logic [W-1:0] r_rd_a;
    logic [W-1:0] r_rd_b;

    tskf_pkg::t_instr    w_ins;
    logic signed [32:0]  w_ext;
    logic signed [W-1:0] w_opa;
    logic signed [W-1:0] w_opb;
    logic signed [W-1:0] w_alu_res;
    logic                w_alu_sat;
    logic                w_div_start;
    logic                w_div_done;
    logic signed [W-1:0] w_div_q;
    logic                w_div_ovf;
    logic signed [W-1:0] w_wb_data;
    logic                w_wb_sat;
    logic                w_wb_en;

    function automatic logic [31:0] to_field(input logic [W-1:0] v);
        logic [W+31:0] t;
        t = {{32{v[W-1]}}, v};
        return t[31:0];
    endfunction

    assign w_ins = tskf_pkg::prog(r_pc);

    // external operand select for loads
    always_comb begin
        case (w_ins.a)
            tskf_pkg::X_DT:  w_ext = {2'b00, r_dt};
            tskf_pkg::X_H0:  w_ext = {r_h0[31], r_h0};
            tskf_pkg::X_H1:  w_ext = {r_h1[31], r_h1};
            tskf_pkg::X_Q0:  w_ext = {2'b00, r_q0};
            tskf_pkg::X_Q1:  w_ext = {2'b00, r_q1};
            tskf_pkg::X_RN:  w_ext = {2'b00, r_rn};
            tskf_pkg::X_Z:   w_ext = {r_in[31], r_in[31:0]};
            tskf_pkg::X_LP:  w_ext = {r_in[63], r_in[63:32]};
            tskf_pkg::X_LV:  w_ext = {r_in[95], r_in[95:64]};
            tskf_pkg::X_L00: w_ext = {r_in[127], r_in[127:96]};
            tskf_pkg::X_L01: w_ext = {r_in[159], r_in[159:128]};
            tskf_pkg::X_L10: w_ext = {r_in[191], r_in[191:160]};
            tskf_pkg::X_L11: w_ext = {r_in[223], r_in[223:192]};
            default:         w_ext = '0;
        endcase
    end

    // never-written slots read as zero
    assign w_opa = r_vld_a ? r_rd_a : '0;
    assign w_opb = r_vld_b ? r_rd_b : '0;

    assign w_div_start = (r_state == S_EXEC) && (w_ins.op == tskf_pkg::OP_DIV);
    assign w_wb_en     = r_state == S_WB;
    assign w_wb_data   = (w_ins.op == tskf_pkg::OP_DIV) ? w_div_q : w_alu_res;
    assign w_wb_sat    = (w_ins.op == tskf_pkg::OP_DIV) ? w_div_ovf : w_alu_sat;

    tskf_alu #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_alu (
        .i_clk (i_clk),
        .i_op  (w_ins.op),
        .i_a   (w_opa),
        .i_b   (w_opb),
        .i_ext (w_ext),
        .o_res (w_alu_res),
        .o_sat (w_alu_sat)
    );

    tskf_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_opa),
        .i_den   (w_opb),
        .o_done  (w_div_done),
        .o_q     (w_div_q),
        .o_ovf   (w_div_ovf)
    );

    // register file: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (w_wb_en) begin
            r_mem[w_ins.dst] <= w_wb_data;
        end
        r_rd_a <= r_mem[w_ins.a];
        r_rd_b <= r_mem[w_ins.b];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= tskf_pkg::RST_STEP_DT;
            r_h0 <= tskf_pkg::RST_OBS_POS;
            r_h1 <= tskf_pkg::RST_OBS_VEL;
            r_q0 <= tskf_pkg::RST_PNOISE_P;
            r_q1 <= tskf_pkg::RST_PNOISE_V;
            r_rn <= tskf_pkg::RST_MNOISE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tskf_pkg::CFG_STEP_DT:  r_dt <= i_cfg_wdata[30:0];
                tskf_pkg::CFG_OBS_POS:  r_h0 <= i_cfg_wdata;
                tskf_pkg::CFG_OBS_VEL:  r_h1 <= i_cfg_wdata;
                tskf_pkg::CFG_PNOISE_P: r_q0 <= i_cfg_wdata[30:0];
                tskf_pkg::CFG_PNOISE_V: r_q1 <= i_cfg_wdata[30:0];
                tskf_pkg::CFG_MNOISE:   r_rn <= i_cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // sequencer and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= tskf_pkg::PC_MEAS;
            r_valid     <= '0;
            r_vld_a     <= 1'b0;
            r_vld_b     <= 1'b0;
            r_out_valid <= 1'b0;
            r_sat       <= 1'b0;
            r_skip      <= 1'b0;
            r_status    <= tskf_pkg::ST_OK;
        end else begin
            r_vld_a <= r_valid[w_ins.a];
            r_vld_b <= r_valid[w_ins.b];
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_in     <= s_axis_tdata;
                        r_pc     <= s_axis_tuser[0] ? tskf_pkg::PC_LOAD : tskf_pkg::PC_MEAS;
                        r_sat    <= 1'b0;
                        r_skip   <= 1'b0;
                        r_out_kp <= '0;
                        r_out_kv <= '0;
                        r_state  <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    if (w_ins.op == tskf_pkg::OP_END) begin
                        r_out_valid <= 1'b1;
                        if (r_skip) begin
                            r_status <= tskf_pkg::ST_SKIP;
                        end else if (r_sat) begin
                            r_status <= tskf_pkg::ST_SAT;
                        end else begin
                            r_status <= tskf_pkg::ST_OK;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_ins.op == tskf_pkg::OP_CHK) begin
                        // a denominator that is not positive skips the update
                        if (w_opa[W-1] || (w_opa == '0)) begin
                            r_skip <= 1'b1;
                            r_pc   <= tskf_pkg::PC_SKIP;
                        end else begin
                            r_pc <= r_pc + 1'b1;
                        end
                        r_state <= S_FETCH;
                    end else if (w_ins.op == tskf_pkg::OP_DIV) begin
                        r_state <= S_DIVW;
                    end else begin
                        r_state <= S_WB;
                    end
                end
                S_DIVW: begin
                    if (w_div_done) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_valid[w_ins.dst] <= 1'b1;
                    r_sat <= r_sat | w_wb_sat;
                    if (w_ins.dst == tskf_pkg::R_POS) r_out_pos <= to_field(w_wb_data);
                    if (w_ins.dst == tskf_pkg::R_VEL) r_out_vel <= to_field(w_wb_data);
                    if (w_ins.dst == tskf_pkg::R_KP)  r_out_kp  <= to_field(w_wb_data);
                    if (w_ins.dst == tskf_pkg::R_KV)  r_out_kv  <= to_field(w_wb_data);
                    r_pc    <= r_pc + 1'b1;
                    r_state <= S_FETCH;
                end
                S_DONE: begin
                    if (m_axis_tready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_kv, r_out_kp, r_out_vel, r_out_pos};
    assign m_axis_tuser  = r_status;

endmodule

[tb/two_state_kalman_filter_unit_test.sv]
// testbench of the two-state kalman filter unit: directed table, random phases, scoreboard
`timescale 1ns / 1ps

module two_state_kalman_filter_unit_test;

    localparam longint MAX_Q = 64'sd2147483647;
    localparam longint MIN_Q = -64'sd2147483648;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 900;
    localparam int PHASE_LEN = 150;

    typedef struct {
        logic [31:0] est_pos;
        logic [31:0] est_vel;
        logic [31:0] gain_pos;
        logic [31:0] gain_vel;
        logic [1:0]  status;
    } t_estimate;

    typedef struct {
        bit                              is_cfg;
        logic [tskf_pkg::CFG_IDX_W-1:0]  idx;
        logic [31:0]                     wdata;
        bit                              cmd;
        logic [223:0]                    data;
        bit                              typed;
        t_estimate                       want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [tskf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [223:0] s_axis_tdata = '0;
    logic [0:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;

    // filter state and registers as the block should hold them
    longint kf_pos, kf_vel, kf_c00, kf_c01, kf_c10, kf_c11;
    longint reg_dt, reg_h0, reg_h1, reg_q0, reg_q1, reg_rn;
    bit clip_seen;

    t_estimate pending_estimates[$];
    int fail_count = 0;
    int result_count = 0;
    int cycle_count = 0;
    t_row steps[$];

    two_state_kalman_filter_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // saturating fixed-point helpers
    function automatic longint clamp(longint v);
        if (v > MAX_Q) begin
            clip_seen = 1'b1;
            return MAX_Q;
        end
        if (v < MIN_Q) begin
            clip_seen = 1'b1;
            return MIN_Q;
        end
        return v;
    endfunction

    function automatic longint qadd(longint a, longint b);
        return clamp(a + b);
    endfunction

    function automatic longint qmul(longint a, longint b);
        bit neg;
        longint ua, ub, r, lim;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        r = (ua * ub) >> 16;
        lim = MAX_Q + (neg ? 1 : 0);
        if (r > lim) begin
            clip_seen = 1'b1;
            r = lim;
        end
        return neg ? -r : r;
    endfunction

    // den is positive here
    function automatic longint qdiv(longint num, longint den);
        bit neg;
        longint u, q, lim;
        neg = num < 0;
        u = neg ? -num : num;
        q = (u << 16) / den;
        lim = MAX_Q + (neg ? 1 : 0);
        if (q > lim) begin
            clip_seen = 1'b1;
            q = lim;
        end
        return neg ? -q : q;
    endfunction

    function automatic void write_register(logic [tskf_pkg::CFG_IDX_W-1:0] idx,
                                           logic [31:0] v);
        case (idx)
            tskf_pkg::CFG_STEP_DT:  reg_dt = longint'(v[30:0]);
            tskf_pkg::CFG_OBS_POS:  reg_h0 = longint'($signed(v));
            tskf_pkg::CFG_OBS_VEL:  reg_h1 = longint'($signed(v));
            tskf_pkg::CFG_PNOISE_P: reg_q0 = longint'(v[30:0]);
            tskf_pkg::CFG_PNOISE_V: reg_q1 = longint'(v[30:0]);
            tskf_pkg::CFG_MNOISE:   reg_rn = longint'(v[30:0]);
            default: ;
        endcase
    endfunction

    // one filter step: predict, gain, update or keep the prediction (or load)
    function automatic t_estimate filter_step(bit cmd, logic [223:0] d);
        t_estimate e;
        longint kp, kv, z, xp0, xp1, r00, r01, p00, p01, p10, p11;
        longint t0, t1, s, innov, u0, u1;
        logic [1:0] st;
        kp = 0;
        kv = 0;
        clip_seen = 1'b0;
        if (cmd) begin
            kf_pos = $signed(d[63:32]);
            kf_vel = $signed(d[95:64]);
            kf_c00 = $signed(d[127:96]);
            kf_c01 = $signed(d[159:128]);
            kf_c10 = $signed(d[191:160]);
            kf_c11 = $signed(d[223:192]);
            st = tskf_pkg::ST_OK;
        end else begin
            z = $signed(d[31:0]);
            xp0 = qadd(kf_pos, qmul(reg_dt, kf_vel));
            xp1 = kf_vel;
            r00 = qadd(kf_c00, qmul(reg_dt, kf_c10));
            r01 = qadd(kf_c01, qmul(reg_dt, kf_c11));
            p00 = qadd(qadd(r00, qmul(r01, reg_dt)), reg_q0);
            p01 = r01;
            p10 = qadd(kf_c10, qmul(kf_c11, reg_dt));
            p11 = qadd(kf_c11, reg_q1);
            t0 = qadd(qmul(p00, reg_h0), qmul(p01, reg_h1));
            t1 = qadd(qmul(p10, reg_h0), qmul(p11, reg_h1));
            s = qadd(reg_rn, qadd(qmul(reg_h0, t0), qmul(reg_h1, t1)));
            if (s <= 0) begin
                kf_pos = xp0;
                kf_vel = xp1;
                kf_c00 = p00;
                kf_c01 = p01;
                kf_c10 = p10;
                kf_c11 = p11;
                st = tskf_pkg::ST_SKIP;
            end else begin
                kp = qdiv(t0, s);
                kv = qdiv(t1, s);
                innov = qadd(z, -qadd(qmul(reg_h0, xp0), qmul(reg_h1, xp1)));
                kf_pos = qadd(xp0, qmul(kp, innov));
                kf_vel = qadd(xp1, qmul(kv, innov));
                u0 = qadd(qmul(reg_h0, p00), qmul(reg_h1, p10));
                u1 = qadd(qmul(reg_h0, p01), qmul(reg_h1, p11));
                kf_c00 = qadd(p00, -qmul(kp, u0));
                kf_c01 = qadd(p01, -qmul(kp, u1));
                kf_c10 = qadd(p10, -qmul(kv, u0));
                kf_c11 = qadd(p11, -qmul(kv, u1));
                st = clip_seen ? tskf_pkg::ST_SAT : tskf_pkg::ST_OK;
            end
        end
        e.est_pos = kf_pos[31:0];
        e.est_vel = kf_vel[31:0];
        e.gain_pos = kp[31:0];
        e.gain_vel = kv[31:0];
        e.status = st;
        return e;
    endfunction

    function automatic t_row cfg_row(logic [tskf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.wdata = v;
        return r;
    endfunction

    function automatic t_row meas_row(logic [31:0] z);
        t_row r;
        r = '{default: '0};
        r.data = {192'd0, z};
        return r;
    endfunction

    // a load shows the loaded state with zero gains
    function automatic t_row load_row(logic [31:0] p, logic [31:0] v, logic [31:0] c00,
                                      logic [31:0] c01, logic [31:0] c10, logic [31:0] c11);
        t_row r;
        r = '{default: '0};
        r.cmd = 1'b1;
        r.data = {c11, c10, c01, c00, v, p, 32'd0};
        r.typed = 1'b1;
        r.want = '{p, v, 32'd0, 32'd0, tskf_pkg::ST_OK};
        return r;
    endfunction

    function automatic t_row typed_meas(logic [31:0] z, t_estimate w);
        t_row r;
        r = meas_row(z);
        r.typed = 1'b1;
        r.want = w;
        return r;
    endfunction

    // configuration write, only with nothing in flight
    task automatic write_cfg(logic [tskf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_estimates.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= v;
        write_register(idx, v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one input transfer; entered and left at a falling edge
    task automatic send_item(bit cmd, logic [223:0] d, bit typed, t_estimate w);
        int gap;
        t_estimate e;
        gap = $urandom_range(0, 7);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        e = filter_step(cmd, d);
        pending_estimates.push_back(typed ? w : e);
        @(negedge i_clk);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    // result side: random stalls, one long hold-off
    initial begin
        t_estimate w;
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = (result_count == 120) ? 3000 : $urandom_range(0, 7);
            if (result_count > 300 && result_count < 400) gap = 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            result_count++;
            if (pending_estimates.size() == 0) begin
                $error("result transfer with no estimate pending");
                fail_count++;
            end else begin
                w = pending_estimates.pop_front();
                check_field("est_pos", w.est_pos, m_axis_tdata[31:0]);
                check_field("est_vel", w.est_vel, m_axis_tdata[63:32]);
                check_field("gain_pos", w.gain_pos, m_axis_tdata[95:64]);
                check_field("gain_vel", w.gain_vel, m_axis_tdata[127:96]);
                check_field("status", {30'd0, w.status}, {30'd0, m_axis_tuser});
            end
        end
    end

    // stimulus
    initial begin
        t_estimate none;
        logic [31:0] cv [6];
        logic [223:0] d;
        int phase, wait_cycles;
        none = '{default: '0};
        reg_dt = tskf_pkg::RST_STEP_DT;
        reg_h0 = $signed(tskf_pkg::RST_OBS_POS);
        reg_h1 = $signed(tskf_pkg::RST_OBS_VEL);
        reg_q0 = tskf_pkg::RST_PNOISE_P;
        reg_q1 = tskf_pkg::RST_PNOISE_V;
        reg_rn = tskf_pkg::RST_MNOISE;
        kf_pos = 0; kf_vel = 0; kf_c00 = 0; kf_c01 = 0; kf_c10 = 0; kf_c11 = 0;

        // directed table
        steps.push_back(typed_meas(32'd0,
                                   '{32'd0, 32'd0, 32'd32768, 32'd0, tskf_pkg::ST_OK}));
        steps.push_back(meas_row(32'h7FFFFFFF));
        steps.push_back(meas_row(32'h80000000));
        steps.push_back(load_row(32'h00050000, 32'hFFFF0000, 32'h00010000, 32'd0, 32'd0,
                                 32'h00010000));
        steps.push_back(meas_row(32'h00030000));
        steps.push_back(load_row('1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1));
        steps.push_back(meas_row(32'h7FFFFFFF));
        steps.push_back(load_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                                 32'h80000000, 32'h80000000));
        steps.push_back(meas_row(32'h80000000));
        // writes past the last register are dropped
        steps.push_back(cfg_row(3'd6, 32'hFFFFFFFF));
        steps.push_back(cfg_row(3'd7, 32'hFFFFFFFF));
        // zero observation and noise: denominator is zero, prediction kept
        steps.push_back(cfg_row(tskf_pkg::CFG_OBS_POS, 32'd0));
        steps.push_back(cfg_row(tskf_pkg::CFG_OBS_VEL, 32'd0));
        steps.push_back(cfg_row(tskf_pkg::CFG_MNOISE, 32'd0));
        steps.push_back(load_row(32'h00050000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0));
        steps.push_back(typed_meas(32'h00010000,
                                   '{32'h00050000, 32'd0, 32'd0, 32'd0, tskf_pkg::ST_SKIP}));
        steps.push_back(cfg_row(tskf_pkg::CFG_STEP_DT, 32'hFFFFFFFF));
        steps.push_back(cfg_row(tskf_pkg::CFG_OBS_POS, 32'h80000000));
        steps.push_back(cfg_row(tskf_pkg::CFG_OBS_VEL, 32'h7FFFFFFF));
        steps.push_back(cfg_row(tskf_pkg::CFG_PNOISE_P, 32'h7FFFFFFF));
        steps.push_back(cfg_row(tskf_pkg::CFG_PNOISE_V, 32'h7FFFFFFF));
        steps.push_back(cfg_row(tskf_pkg::CFG_MNOISE, 32'h7FFFFFFF));
        steps.push_back(meas_row(32'h80000000));
        steps.push_back(meas_row(32'h7FFFFFFF));

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (steps[i]) begin
            if (steps[i].is_cfg) write_cfg(steps[i].idx, steps[i].wdata);
            else send_item(steps[i].cmd, steps[i].data, steps[i].typed, steps[i].want);
        end

        // random phases, each with its own register setting
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_LEN == 0) begin
                phase = n / PHASE_LEN;
                s_axis_tvalid <= 1'b0;
                if (phase == 1) begin
                    cv = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
                end else if (phase == 3) begin
                    cv = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
                end else begin
                    cv[0] = $urandom_range(0, 131072);
                    cv[1] = $urandom_range(32768, 131072);
                    cv[2] = $urandom_range(0, 16384) - 8192;
                    cv[3] = $urandom_range(0, 4096);
                    cv[4] = $urandom_range(0, 4096);
                    cv[5] = $urandom_range(1, 1 << 20);
                end
                write_cfg(tskf_pkg::CFG_STEP_DT, cv[0]);
                write_cfg(tskf_pkg::CFG_OBS_POS, cv[1]);
                write_cfg(tskf_pkg::CFG_OBS_VEL, cv[2]);
                write_cfg(tskf_pkg::CFG_PNOISE_P, cv[3]);
                write_cfg(tskf_pkg::CFG_PNOISE_V, cv[4]);
                write_cfg(tskf_pkg::CFG_MNOISE, cv[5]);
            end
            if ($urandom_range(0, 99) < 85) begin
                d = '0;
                d[31:0] = ($urandom_range(0, 9) == 0) ? $urandom
                          : $urandom_range(0, 1 << 22) - (1 << 21);
                send_item(1'b0, d, 1'b0, none);
            end else if ($urandom_range(0, 1) == 0) begin
                d = {$urandom_range(0, 1 << 18), 32'd0, 32'd0, $urandom_range(0, 1 << 18),
                     $urandom_range(0, 1 << 20) - (1 << 19),
                     $urandom_range(0, 1 << 24) - (1 << 23), $urandom};
                send_item(1'b1, d, 1'b0, none);
            end else begin
                d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
                send_item(1'b1, d, 1'b0, none);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_estimates.size() != 0) @(posedge i_clk);
        wait_cycles = 400;
        repeat (wait_cycles) @(posedge i_clk);
        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
rtl/tskf_pkg.sv
rtl/tskf_div.sv
rtl/tskf_alu.sv
rtl/two_state_kalman_filter_unit.sv
tb/two_state_kalman_filter_unit_test.sv
